[src/spcr_pkg.sv]
`default_nettype none

package spcr_pkg;

	// widths of the mass-sum divider
	localparam int unsigned NumW     = 64;
	localparam int unsigned DenW     = 32;
	localparam int unsigned QuoW     = 32;
	localparam int unsigned DivSteps = QuoW - 1;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	localparam logic [QuoW-1:0] SatPos = {1'b0, {(QuoW-1){1'b1}}};
	localparam logic [QuoW-1:0] SatNeg = {1'b1, {(QuoW-1){1'b0}}};

	typedef struct packed {
		logic               is_check;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [30:0]        radius;
		logic [30:0]        mass;
	} in_word_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] ref_new_vx;
		logic signed [31:0] ref_new_vy;
		logic signed [31:0] ref_new_vz;
		logic signed [31:0] other_new_vx;
		logic signed [31:0] other_new_vy;
		logic signed [31:0] other_new_vz;
	} out_word_t;

	typedef struct packed {
		logic            start;
		logic            neg;
		logic [NumW-1:0] num;
		logic [DenW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [QuoW-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

[src/sphere_pair_collide_respond_top.sv]
// Sphere pair collision test and elastic response, signed fixed point. A load
// word (is_check low) stores the reference ball and gives no
// result. A check word tests its ball against the reference: hit when the
// squared center distance is below the squared radius sum and the balls
// approach; on a hit both velocities take the per-component elastic formula
// (quotient truncated toward zero, saturated to 32 bits) and the reference
// velocity is updated in place. Without a loaded reference, or without a hit,
// both velocities pass through. One 32x32 multiplier, used in turn for every
// product, and one serial divider, one quotient bit a cycle, do all the work
// under a small sequencer; in_ready is high only while the sequencer idles.
// A hit runs six mass-sum divisions on the shared divider (a saturated
// quotient ends its division early; a zero mass sum skips it). One
// output register holds the result word until taken.
`default_nettype none

module sphere_pair_collide_respond_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  spcr_pkg::in_word_t    in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output spcr_pkg::out_word_t   out_word
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MUL    = 6'b000010,
		S_DECIDE = 6'b000100,
		S_EMUL   = 6'b001000,
		S_DIV    = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	// distance phase steps: radius sum first, then two products per axis
	localparam logic [2:0] MulTagR2   = 3'd0;
	localparam logic [2:0] MulTagLast = 3'd6;
	localparam logic [2:0] MulStepEnd = 3'd7;
	// response phase steps for one component
	localparam logic [2:0] EStepMulA  = 3'd0;
	localparam logic [2:0] EStepMulB  = 3'd1;
	localparam logic [2:0] EStepSum   = 3'd2;
	localparam logic [2:0] EStepNum   = 3'd3;
	localparam logic [1:0] LastComp   = 2'd2;

	state_t               state_q;
	logic [2:0]           step_q;
	logic [1:0]           comp_q;
	logic                 dir_q;
	logic                 hit_q;

	// reference ball
	logic                 ref_valid_q;
	logic signed [31:0]   ref_pos_q [3];
	logic signed [31:0]   ref_vel_q [3];
	logic [30:0]          ref_rad_q;
	logic [30:0]          ref_mass_q;

	// checked ball and working registers
	spcr_pkg::in_word_t   item_q;
	logic [63:0]          prod_q;
	logic                 pvld_q;
	logic [2:0]           ptag_q;
	logic                 psgn_q;
	logic [63:0]          r2_q;
	logic [65:0]          dist_q;
	logic [66:0]          dot_q;
	logic [63:0]          t1_q;
	logic                 t1neg_q;
	logic [65:0]          sum_q;
	logic signed [31:0]   nvr_q [3];
	logic signed [31:0]   nvo_q [3];
	logic                 out_valid_q;
	spcr_pkg::out_word_t  out_word_q;

	logic                 in_fire;
	logic                 ld_fire;
	logic                 ck_fire;
	logic                 out_load;
	logic                 hit;
	logic                 last_div;

	logic signed [31:0]   ipos [3];
	logic signed [31:0]   ivel [3];
	logic [1:0]           mc;
	logic [1:0]           cidx;
	logic signed [31:0]   rp;
	logic signed [31:0]   ip;
	logic signed [31:0]   rv;
	logic signed [31:0]   ov;
	logic [32:0]          dp;
	logic [32:0]          dv;
	logic [32:0]          dp_abs;
	logic [32:0]          dv_abs;
	logic [31:0]          ap;
	logic [31:0]          av;
	logic [31:0]          rsum;

	logic signed [31:0]   va;
	logic signed [31:0]   vb;
	logic [30:0]          ma;
	logic [30:0]          mb;
	logic [31:0]          va_abs;
	logic [31:0]          vb_abs;
	logic [31:0]          mdiff;
	logic [31:0]          mdiff_abs;
	logic [31:0]          den;
	logic [65:0]          s1;
	logic [65:0]          s2;
	logic [65:0]          nabs;

	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          mul_p;

	spcr_pkg::div_req_t   div_req;
	spcr_pkg::div_rsp_t   div_rsp;

	assign in_ready = state_q == S_IDLE;
	assign in_fire  = in_valid && in_ready;
	assign ld_fire  = in_fire && !in_word.is_check;
	assign ck_fire  = in_fire && in_word.is_check;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign ipos[0] = item_q.pos_x;
	assign ipos[1] = item_q.pos_y;
	assign ipos[2] = item_q.pos_z;
	assign ivel[0] = item_q.vel_x;
	assign ivel[1] = item_q.vel_y;
	assign ivel[2] = item_q.vel_z;

	// axis of the product issued in this distance step
	always_comb begin
		case (step_q) inside
			[3'd1:3'd2]: mc = 2'd0;
			[3'd3:3'd4]: mc = 2'd1;
			[3'd5:3'd6]: mc = 2'd2;
			default:     mc = 2'd0;
		endcase
	end

	// one axis select serves both phases
	assign cidx = (state_q == S_MUL) ? mc : comp_q;
	assign rp   = ref_pos_q[cidx];
	assign ip   = ipos[cidx];
	assign rv   = ref_vel_q[cidx];
	assign ov   = ivel[cidx];

	// displacement and relative velocity, ref minus other; magnitudes fit 32 bits
	assign dp     = {rp[31], rp} - {ip[31], ip};
	assign dv     = {rv[31], rv} - {ov[31], ov};
	assign dp_abs = dp[32] ? -dp : dp;
	assign dv_abs = dv[32] ? -dv : dv;
	assign ap     = dp_abs[31:0];
	assign av     = dv_abs[31:0];
	assign rsum   = {1'b0, ref_rad_q} + {1'b0, item_q.radius};

	// elastic operands, seen from ball a (reference when dir_q is low)
	assign va        = dir_q ? ov : rv;
	assign vb        = dir_q ? rv : ov;
	assign ma        = dir_q ? item_q.mass : ref_mass_q;
	assign mb        = dir_q ? ref_mass_q : item_q.mass;
	assign va_abs    = va[31] ? -va : va;
	assign vb_abs    = vb[31] ? -vb : vb;
	assign mdiff     = {1'b0, ma} - {1'b0, mb};
	assign mdiff_abs = mdiff[31] ? -mdiff : mdiff;
	assign den       = {1'b0, ma} + {1'b0, mb};

	assign s1   = t1neg_q ? -{2'b0, t1_q} : {2'b0, t1_q};
	assign s2   = vb[31] ? -{2'b0, prod_q} : {2'b0, prod_q};
	assign nabs = sum_q[65] ? -sum_q : sum_q;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL: begin
				if (step_q == MulTagR2) begin
					mul_a = rsum;
					mul_b = rsum;
				end else if (step_q[0]) begin
					mul_a = ap;
					mul_b = ap;
				end else begin
					mul_a = ap;
					mul_b = av;
				end
			end
			S_EMUL: begin
				if (step_q == EStepMulA) begin
					mul_a = va_abs;
					mul_b = mdiff_abs;
				end else begin
					mul_a = vb_abs;
					mul_b = {mb, 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// overlap and approach
	assign hit = ref_valid_q && (dist_q < {2'b0, r2_q}) && dot_q[66];

	assign last_div = dir_q && (comp_q == LastComp);

	// start a division unless the mass sum is zero
	assign div_req.start = (state_q == S_EMUL) && (step_q == EStepNum) && (den != '0);
	assign div_req.neg   = sum_q[65];
	assign div_req.num   = nabs[63:0];
	assign div_req.den   = den;

	spcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer and reference state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			comp_q      <= '0;
			dir_q       <= 1'b0;
			hit_q       <= 1'b0;
			pvld_q      <= 1'b0;
			out_valid_q <= 1'b0;
			ref_valid_q <= 1'b0;
			ref_rad_q   <= '0;
			ref_mass_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				ref_pos_q[i] <= '0;
				ref_vel_q[i] <= '0;
			end
		end else begin
			pvld_q <= (state_q == S_MUL) && (step_q <= MulTagLast);
			// load a new result word or drop the one just taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ld_fire) begin
						ref_valid_q  <= 1'b1;
						ref_pos_q[0] <= in_word.pos_x;
						ref_pos_q[1] <= in_word.pos_y;
						ref_pos_q[2] <= in_word.pos_z;
						ref_vel_q[0] <= in_word.vel_x;
						ref_vel_q[1] <= in_word.vel_y;
						ref_vel_q[2] <= in_word.vel_z;
						ref_rad_q    <= in_word.radius;
						ref_mass_q   <= in_word.mass;
					end else if (ck_fire) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == MulStepEnd) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					hit_q  <= hit;
					comp_q <= '0;
					dir_q  <= 1'b0;
					step_q <= EStepMulA;
					state_q <= hit ? S_EMUL : S_OUT;
				end
				S_EMUL: begin
					if (step_q == EStepNum) begin
						step_q <= EStepMulA;
						if (den != '0) begin
							state_q <= S_DIV;
						end else if (last_div) begin
							state_q <= S_OUT;
						end else if (comp_q == LastComp) begin
							comp_q <= '0;
							dir_q  <= 1'b1;
						end else begin
							comp_q <= comp_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (last_div) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_EMUL;
							if (comp_q == LastComp) begin
								comp_q <= '0;
								dir_q  <= 1'b1;
							end else begin
								comp_q <= comp_q + 1'b1;
							end
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
						if (hit_q) begin
							for (int i = 0; i < 3; i++) begin
								ref_vel_q[i] <= nvr_q[i];
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		ptag_q <= step_q;
		psgn_q <= dp[32] ^ dv[32];

		if (ck_fire) begin
			item_q <= in_word;
			dist_q <= '0;
			dot_q  <= '0;
		end

		// fold the registered product of the step before
		if (pvld_q) begin
			if (ptag_q == MulTagR2) begin
				r2_q <= prod_q;
			end else if (ptag_q[0]) begin
				dist_q <= dist_q + {2'b0, prod_q};
			end else begin
				dot_q <= dot_q + (psgn_q ? -{3'b0, prod_q} : {3'b0, prod_q});
			end
		end

		// no hit: pass both velocities through
		if (state_q == S_DECIDE && !hit) begin
			for (int i = 0; i < 3; i++) begin
				nvr_q[i] <= ref_vel_q[i];
				nvo_q[i] <= ivel[i];
			end
		end

		if (state_q == S_EMUL) begin
			if (step_q == EStepMulB) begin
				t1_q    <= prod_q;
				t1neg_q <= va[31] ^ mdiff[31];
			end
			if (step_q == EStepSum) begin
				sum_q <= s1 + s2;
			end
			// zero mass sum: keep the old velocity
			if (step_q == EStepNum && den == '0) begin
				if (dir_q) begin
					nvo_q[comp_q] <= va;
				end else begin
					nvr_q[comp_q] <= va;
				end
			end
		end

		if (state_q == S_DIV && div_rsp.done) begin
			if (dir_q) begin
				nvo_q[comp_q] <= div_rsp.quo;
			end else begin
				nvr_q[comp_q] <= div_rsp.quo;
			end
		end

		if (out_load) begin
			out_word_q.hit          <= hit_q;
			out_word_q.ref_new_vx   <= nvr_q[0];
			out_word_q.ref_new_vy   <= nvr_q[1];
			out_word_q.ref_new_vz   <= nvr_q[2];
			out_word_q.other_new_vx <= nvo_q[0];
			out_word_q.other_new_vy <= nvo_q[1];
			out_word_q.other_new_vz <= nvo_q[2];
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_div_start_in_num_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == S_EMUL) && (step_q == EStepNum))
		else $error("divider started outside the numerator step");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished while the sequencer was not waiting");

	a_hit_needs_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.hit) |-> ref_valid_q)
		else $error("hit reported without a loaded reference");

	a_ref_vel_write: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ref_vel_q[0]) |-> $past(ld_fire || (out_load && hit_q)))
		else $error("reference velocity changed without a load or a hit");

endmodule

`default_nettype wire

[src/spcr_div.sv]
`default_nettype none

// Serial restoring divider: magnitude numerator over mass sum, one quotient
// bit a cycle, signed and saturated result.
module spcr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  spcr_pkg::div_req_t  req,
	output spcr_pkg::div_rsp_t  rsp
);

	logic                              busy_q;
	logic                              chk_q;
	logic                              done_q;
	logic [spcr_pkg::DivCntW-1:0]      cnt_q;
	logic                              neg_q;
	logic [spcr_pkg::DenW:0]           rem_q;
	logic [spcr_pkg::DivSteps-1:0]     sh_q;
	logic [spcr_pkg::DenW-1:0]         den_q;
	logic [spcr_pkg::QuoW-1:0]         quo_q;

	logic                              sat;
	logic                              last;
	logic [spcr_pkg::DenW:0]           trial;
	logic                              fits;
	logic [spcr_pkg::DivSteps-1:0]     sh_next;
	logic [spcr_pkg::QuoW-1:0]         quo_mag;

	// quotient at or above 2^31 when the upper numerator bits reach the divisor
	assign sat     = rem_q >= {1'b0, den_q};
	assign last    = cnt_q == spcr_pkg::DivCntW'(spcr_pkg::DivSteps - 1);
	assign trial   = {rem_q[spcr_pkg::DenW-1:0], sh_q[spcr_pkg::DivSteps-1]};
	assign fits    = trial >= {1'b0, den_q};
	assign sh_next = {sh_q[spcr_pkg::DivSteps-2:0], fits};
	assign quo_mag = {1'b0, sh_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				chk_q  <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q && chk_q) begin
				chk_q  <= 1'b0;
				done_q <= sat;
				if (sat) begin
					busy_q <= 1'b0;
				end
			end else if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				done_q <= last;
				if (last) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[spcr_pkg::NumW-1:spcr_pkg::DivSteps];
			sh_q  <= req.num[spcr_pkg::DivSteps-1:0];
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (busy_q && chk_q) begin
			if (sat) begin
				quo_q <= neg_q ? spcr_pkg::SatNeg : spcr_pkg::SatPos;
			end
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			sh_q  <= sh_next;
			if (last) begin
				quo_q <= neg_q ? -quo_mag : quo_mag;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

[bench/collide_check.sv]
module collide_check
	import spcr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_word,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_word,
	output int        mismatch_count,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [79:0] QuoMax = 80'sd2147483647;
	localparam logic signed [79:0] QuoMin = -80'sd2147483648;

	// shadow copy of the stored reference ball
	logic               anchor_loaded;
	logic signed [31:0] anchor_pos [0:2];
	logic signed [31:0] anchor_vel [0:2];
	logic [31:0]        anchor_rad;
	logic [31:0]        anchor_mass;

	out_word_t expected_velocities [$];
	out_word_t want;

	// one component of the 1D elastic exchange, seen from ball a
	function automatic logic signed [31:0] elastic_velocity(
		input logic signed [31:0] va,
		input logic signed [31:0] vb,
		input logic [31:0]        ma,
		input logic [31:0]        mb
	);
		logic signed [79:0] wa, wb, sma, smb, num, den, quo;
		wa  = va;
		wb  = vb;
		sma = $signed({48'd0, ma});
		smb = $signed({48'd0, mb});
		den = sma + smb;
		if (den == 0)
			return va;
		num = wa * (sma - smb) + wb * (smb + smb);
		quo = num / den;
		if (quo > QuoMax)
			return QuoMax[31:0];
		if (quo < QuoMin)
			return QuoMin[31:0];
		return quo[31:0];
	endfunction

	task automatic resolve_pair(input in_word_t w, output out_word_t r);
		logic signed [31:0] opos [0:2];
		logic signed [31:0] ovel [0:2];
		logic signed [31:0] rv_out [0:2];
		logic signed [31:0] ov_out [0:2];
		logic signed [79:0] dp, dv, dist_sq, dot, rsum, r2;
		logic               hit;
		opos[0] = w.pos_x; opos[1] = w.pos_y; opos[2] = w.pos_z;
		ovel[0] = w.vel_x; ovel[1] = w.vel_y; ovel[2] = w.vel_z;
		hit = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rv_out[i] = anchor_vel[i];
			ov_out[i] = ovel[i];
		end
		if (anchor_loaded) begin
			rsum    = $signed({48'd0, anchor_rad}) + $signed({49'd0, w.radius});
			r2      = rsum * rsum;
			dist_sq = 0;
			dot     = 0;
			for (int i = 0; i < 3; i++) begin
				dp      = anchor_pos[i] - opos[i];
				dv      = anchor_vel[i] - ovel[i];
				dist_sq = dist_sq + dp * dp;
				dot     = dot + dp * dv;
			end
			hit = (dist_sq < r2) && (dot < 0);
			if (hit) begin
				for (int i = 0; i < 3; i++) begin
					rv_out[i] = elastic_velocity(anchor_vel[i], ovel[i], anchor_mass,
						{1'b0, w.mass});
					ov_out[i] = elastic_velocity(ovel[i], anchor_vel[i], {1'b0, w.mass},
						anchor_mass);
				end
				for (int i = 0; i < 3; i++)
					anchor_vel[i] = rv_out[i];
			end
		end
		r.hit          = hit;
		r.ref_new_vx   = rv_out[0];
		r.ref_new_vy   = rv_out[1];
		r.ref_new_vz   = rv_out[2];
		r.other_new_vx = ov_out[0];
		r.other_new_vy = ov_out[1];
		r.other_new_vz = ov_out[2];
	endtask

	task automatic take_ball(input in_word_t w);
		out_word_t r;
		if (!w.is_check) begin
			anchor_pos[0] = w.pos_x; anchor_pos[1] = w.pos_y; anchor_pos[2] = w.pos_z;
			anchor_vel[0] = w.vel_x; anchor_vel[1] = w.vel_y; anchor_vel[2] = w.vel_z;
			anchor_rad    = {1'b0, w.radius};
			anchor_mass   = {1'b0, w.mass};
			anchor_loaded = 1'b1;
		end else begin
			resolve_pair(w, r);
			expected_velocities.push_back(r);
		end
	endtask

	task automatic check_field(input string fname, input logic signed [31:0] exp_v,
		input logic signed [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_loaded = 1'b0;
			for (int i = 0; i < 3; i++) begin
				anchor_pos[i] = '0;
				anchor_vel[i] = '0;
			end
			anchor_rad  = '0;
			anchor_mass = '0;
			expected_velocities.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_velocities.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual hit=%0d",
						$time, out_word.hit);
					mismatch_count++;
				end else begin
					want = expected_velocities.pop_front();
					check_field("hit", 32'(want.hit), 32'(out_word.hit));
					check_field("ref_new_vx", want.ref_new_vx, out_word.ref_new_vx);
					check_field("ref_new_vy", want.ref_new_vy, out_word.ref_new_vy);
					check_field("ref_new_vz", want.ref_new_vz, out_word.ref_new_vz);
					check_field("other_new_vx", want.other_new_vx, out_word.other_new_vx);
					check_field("other_new_vy", want.other_new_vy, out_word.other_new_vy);
					check_field("other_new_vz", want.other_new_vz, out_word.other_new_vz);
				end
			end
			if (in_valid && in_ready)
				take_ball(in_word);
			outstanding = expected_velocities.size();
		end
	end

endmodule

[bench/tb_top.sv]
module tb_top;
	import spcr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                 RandItems  = 800;
	localparam int                 CycleLimit = 1500000;
	localparam int                 TailCycles = 300;
	localparam logic signed [31:0] One        = 32'sd65536;
	localparam logic [30:0]        OneU       = 31'd65536;
	localparam logic signed [31:0] SMax       = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SMin       = 32'sh8000_0000;
	localparam logic [30:0]        UMax       = 31'h7FFF_FFFF;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_word_t  in_word   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	out_word_t out_word;

	int mismatch_count;
	int outstanding;
	int cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	// stimulus-side memory of the last loaded reference, used to aim the
	// check words so that most of them land near it
	bit                 anchor_set = 1'b0;
	logic signed [31:0] anchor_pos [0:2];
	logic [30:0]        anchor_rad;

	sphere_pair_collide_respond_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	collide_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_word        (in_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_word       (out_word),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then a long one; calm
	// stretches suppress idling on both sides
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: stall at random, flip calm mode once in a while
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0)
			calm = !calm;
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	function automatic in_word_t mk_ball(input bit chk,
		input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [31:0] pz, input logic signed [31:0] vx,
		input logic signed [31:0] vy, input logic signed [31:0] vz,
		input logic [30:0] r, input logic [30:0] m);
		in_word_t w;
		w.is_check = chk;
		w.pos_x    = px;
		w.pos_y    = py;
		w.pos_z    = pz;
		w.vel_x    = vx;
		w.vel_y    = vy;
		w.vel_z    = vz;
		w.radius   = r;
		w.mass     = m;
		return w;
	endfunction

	// random signed value, arithmetic shift sets its magnitude
	function automatic logic signed [31:0] scaled_s32(input int shift);
		logic signed [31:0] s;
		s = $urandom;
		return s >>> shift;
	endfunction

	function automatic logic [30:0] rand_u31(input int lo_shift, input int hi_shift);
		logic [31:0] u;
		u = $urandom;
		u = u >> $urandom_range(lo_shift, hi_shift);
		return u[30:0];
	endfunction

	function automatic logic [30:0] rand_mass();
		logic [30:0] m;
		m = rand_u31(0, 30);
		if (m == 0)
			m = 31'd1;
		return m;
	endfunction

	function automatic void note_load(input in_word_t w);
		if (!w.is_check) begin
			anchor_set    = 1'b1;
			anchor_pos[0] = w.pos_x;
			anchor_pos[1] = w.pos_y;
			anchor_pos[2] = w.pos_z;
			anchor_rad    = w.radius;
		end
	endfunction

	// new reference ball of moderate size
	function automatic in_word_t load_ball();
		in_word_t w;
		w = mk_ball(1'b0,
			scaled_s32($urandom_range(2, 16)), scaled_s32($urandom_range(2, 16)),
			scaled_s32($urandom_range(2, 16)), scaled_s32($urandom_range(4, 20)),
			scaled_s32($urandom_range(4, 20)), scaled_s32($urandom_range(4, 20)),
			rand_u31(8, 24), rand_mass());
		note_load(w);
		return w;
	endfunction

	// check ball inside the radius sum of the reference, mostly moving toward it
	function automatic in_word_t near_ball();
		in_word_t           w;
		logic [31:0]        rsum, half;
		logic signed [31:0] off [0:2];
		logic signed [31:0] pos [0:2];
		logic signed [31:0] vel [0:2];
		logic signed [31:0] mag;
		bit                 approach;
		w.is_check = 1'b1;
		w.radius   = rand_u31(8, 24);
		w.mass     = rand_mass();
		rsum       = {1'b0, anchor_rad} + {1'b0, w.radius};
		half       = rsum >> 1;
		approach   = ($urandom_range(0, 4) != 0);
		for (int i = 0; i < 3; i++) begin
			off[i] = $urandom_range(0, half);
			if ($urandom_range(0, 1) == 1)
				off[i] = -off[i];
			pos[i] = anchor_pos[i] + off[i];
			vel[i] = scaled_s32($urandom_range(5, 20));
			if (approach) begin
				mag    = (vel[i] < 0) ? -vel[i] : vel[i];
				vel[i] = (off[i] < 0) ? mag : -mag;
			end
		end
		w.pos_x = pos[0]; w.pos_y = pos[1]; w.pos_z = pos[2];
		w.vel_x = vel[0]; w.vel_y = vel[1]; w.vel_z = vel[2];
		return w;
	endfunction

	// full-range noise word, load or check
	function automatic in_word_t noise_ball();
		in_word_t w;
		w = mk_ball(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, rand_u31(0, 0), rand_mass());
		note_load(w);
		return w;
	endfunction

	// Drive one input word. Enter and leave at a falling edge; hold valid and
	// the payload until the handshake completes at a rising edge.
	task automatic send(input in_word_t w);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Hold off the sender until every expected result word has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	initial begin
		in_word_t w;
		int       pick;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// check with nothing loaded: no hit, velocities pass through
		send(mk_ball(1'b1, SMax, SMin, 0, SMax, SMin, -1, UMax, UMax));
		// unit reference at the origin, at rest
		send(mk_ball(1'b0, 0, 0, 0, 0, 0, 0, OneU, OneU));
		// exactly touching: distance equals radius sum, no hit
		send(mk_ball(1'b1, 2 * One, 0, 0, -One, 0, 0, OneU, OneU));
		// overlapping but moving apart
		send(mk_ball(1'b1, One, 0, 0, One, 0, 0, OneU, OneU));
		// overlapping, relative velocity perpendicular to displacement
		send(mk_ball(1'b1, One, 0, 0, 0, One, 0, OneU, OneU));
		// concentric: zero displacement, no approach
		send(mk_ball(1'b1, 0, 0, 0, One, One, One, OneU, OneU));
		// head-on hit, equal masses: velocities swap
		send(mk_ball(1'b1, One, 0, 0, -One, 0, 0, OneU, OneU));
		// same reference again with its updated velocity, unequal masses
		send(mk_ball(1'b1, -One, 0, 0, One + 3, 5, -7, OneU, 31'd3));
		// light fast reference against a heavy opposite ball: positive saturation
		send(mk_ball(1'b0, 0, 0, 0, SMin, SMin, SMin, 31'd1, 31'd1));
		send(mk_ball(1'b1, -1, 0, 0, SMax, SMax, SMax, 31'd1, UMax));
		// mirrored case: negative saturation
		send(mk_ball(1'b0, 0, 0, 0, SMax, SMax, SMax, 31'd1, 31'd1));
		send(mk_ball(1'b1, 1, 0, 0, SMin, SMin, SMin, 31'd1, UMax));
		// extreme reference: widest radius and mass
		send(mk_ball(1'b0, SMax, SMax, SMax, SMin, SMax, 0, UMax, UMax));
		// opposite corner: distance far beyond any radius sum
		send(mk_ball(1'b1, SMin, SMin, SMin, SMax, SMin, 0, UMax, UMax));
		// adjacent to the extreme reference, both heaviest: hit
		send(mk_ball(1'b1, SMax - 1, SMax, SMax, SMax, SMin, 0, UMax, UMax));
		// point reference: zero radius, lightest mass
		send(mk_ball(1'b0, 0, 0, 0, 0, 0, 0, 31'd0, 31'd1));
		send(mk_ball(1'b1, 0, 0, 0, -1, 0, 0, 31'd0, 31'd1));
		send(mk_ball(1'b1, 1, 0, 0, -1, 0, 0, 31'd1, 31'd1));
		anchor_set = 1'b0;

		// let the directed words finish before the random part
		drain();

		for (int n = 0; n < RandItems; n++) begin
			if (n == RandItems / 2)
				drain();
			pick = $urandom_range(0, 99);
			if (!anchor_set || pick < 10)
				w = load_ball();
			else if (pick < 75)
				w = near_ball();
			else
				w = noise_ball();
			send(w);
		end

		// wait out the last results, then give stray words time to show up
		drain();
		repeat (TailCycles) @(negedge clk);

		if (mismatch_count == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
src/spcr_pkg.sv
src/spcr_div.sv
src/sphere_pair_collide_respond_top.sv
bench/collide_check.sv
bench/tb_top.sv
